// ----- rtl/kbc_pkg.sv -----
// Shared types, constants and state encodings for the bottleneck clustering block.
`default_nettype none
package kbc_pkg;

  localparam int COORD_W  = 16;
  localparam int DIST_W   = 33;
  localparam int ROOT_W   = 17;
  localparam int TARGET_W = 7;
  localparam int CFG_W    = 32;

  // Register index of the target cluster count.
  localparam logic REG_TARGET = 1'b0;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [ROOT_W-1:0] root_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef enum logic [2:0] {
    T_LOAD, T_MST, T_SEL, T_SQRT, T_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    M_IDLE, M_INIT, M_INITW, M_SCAN, M_DRAIN, M_NEXT
  } mst_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RDI, S_CAPI, S_SCAN, S_DRAIN, S_CHECK
  } sel_state_t;

  typedef enum logic [1:0] {
    Q_IDLE, Q_STEP, Q_FIX
  } sqrt_state_t;

  // Tree edge weight handed from the spanning tree engine to the selector.
  typedef struct packed {
    logic  valid;
    dist_t data;
  } weight_msg_t;

endpackage
`default_nettype wire

// ----- rtl/kbc_mst.sv -----
// Minimum spanning tree engine: point store, key memory and a pipelined Prim scan.
`default_nettype none
module kbc_mst #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pt_wr_en,
  input  logic [$clog2(MAX_POINTS)-1:0]    pt_wr_idx,
  input  kbc_pkg::point_t                  pt_wr_data,
  input  logic                             start,
  input  logic [$clog2(MAX_POINTS+1)-1:0]  num_points,
  output kbc_pkg::weight_msg_t             weight,
  output logic [$clog2(MAX_POINTS)-1:0]    weight_idx,
  output logic                             done
);
  import kbc_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  point_t point_mem [MAX_POINTS];
  dist_t  key_mem   [MAX_POINTS];

  mst_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]      scan_r, scan_nxt;
  logic [IDX_W-1:0]      round_r, round_nxt;
  logic                  first_r, first_nxt;
  logic [MAX_POINTS-1:0] tree_r, tree_nxt;
  point_t                u_pt_r, u_pt_nxt;
  dist_t                 best_key_r;
  logic [IDX_W-1:0]      best_idx_r;
  point_t                best_pt_r;
  logic                  clear_best;

  logic [IDX_W-1:0]      rd_addr;
  logic                  scan_rd;
  point_t                pt_q;
  dist_t                 key_q;

  logic                  s1_vld_r, s2_vld_r, s3_vld_r;
  logic [IDX_W-1:0]      s1_idx_r, s2_idx_r, s3_idx_r;
  logic [COORD_W-1:0]    s2_ax_r, s2_ay_r;
  dist_t                 s2_key_r, s3_key_r;
  point_t                s2_pt_r, s3_pt_r;
  logic [2*COORD_W-1:0]  s3_sqx_r, s3_sqy_r;

  logic [IDX_W-1:0]      last_idx, last_round;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]      adx, ady;
  dist_t                 dsum, new_key;
  logic                  better;

  assign last_idx   = IDX_W'(num_points - 1'b1);
  assign last_round = IDX_W'(num_points - 2'd2);

  // Memories: point store written while loading, key memory by the last scan stage.
  always_ff @(posedge clk) begin
    if (pt_wr_en) begin
      point_mem[pt_wr_idx] <= pt_wr_data;
    end
    if (s3_vld_r) begin
      key_mem[s3_idx_r] <= new_key;
    end
    pt_q  <= point_mem[rd_addr];
    key_q <= key_mem[rd_addr];
  end

  // Scan sequencing.
  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    round_nxt  = round_r;
    first_nxt  = first_r;
    tree_nxt   = tree_r;
    u_pt_nxt   = u_pt_r;
    rd_addr    = '0;
    scan_rd    = 1'b0;
    clear_best = 1'b0;
    done       = 1'b0;
    weight     = '0;
    case (state_r)
      M_IDLE: begin
        if (start) begin
          tree_nxt  = MAX_POINTS'(1);
          round_nxt = '0;
          first_nxt = 1'b1;
          state_nxt = M_INIT;
        end
      end
      M_INIT: begin
        state_nxt = M_INITW;
      end
      M_INITW: begin
        u_pt_nxt   = pt_q;
        scan_nxt   = '0;
        clear_best = 1'b1;
        state_nxt  = M_SCAN;
      end
      M_SCAN: begin
        rd_addr = scan_r;
        scan_rd = 1'b1;
        if (scan_r == last_idx) begin
          state_nxt = M_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      M_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !s3_vld_r) begin
          state_nxt = M_NEXT;
        end
      end
      M_NEXT: begin
        weight.valid         = 1'b1;
        weight.data          = best_key_r;
        tree_nxt[best_idx_r] = 1'b1;
        u_pt_nxt             = best_pt_r;
        first_nxt            = 1'b0;
        clear_best           = 1'b1;
        scan_nxt             = '0;
        if (round_r == last_round) begin
          done      = 1'b1;
          state_nxt = M_IDLE;
        end else begin
          round_nxt = round_r + 1'b1;
          state_nxt = M_SCAN;
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  assign weight_idx = round_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= M_IDLE;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= scan_rd;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    round_r  <= round_nxt;
    first_r  <= first_nxt;
    tree_r   <= tree_nxt;
    u_pt_r   <= u_pt_nxt;
    s1_idx_r <= rd_addr;
  end

  // Stage one: absolute coordinate differences to the newest tree node.
  assign dx  = {pt_q.x[COORD_W-1], pt_q.x} - {u_pt_r.x[COORD_W-1], u_pt_r.x};
  assign dy  = {pt_q.y[COORD_W-1], pt_q.y} - {u_pt_r.y[COORD_W-1], u_pt_r.y};
  assign adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
  assign ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);

  always_ff @(posedge clk) begin
    s2_idx_r <= s1_idx_r;
    s2_ax_r  <= adx[COORD_W-1:0];
    s2_ay_r  <= ady[COORD_W-1:0];
    s2_key_r <= key_q;
    s2_pt_r  <= pt_q;
    // Stage two: squares.
    s3_idx_r <= s2_idx_r;
    s3_sqx_r <= (2*COORD_W)'(s2_ax_r) * (2*COORD_W)'(s2_ax_r);
    s3_sqy_r <= (2*COORD_W)'(s2_ay_r) * (2*COORD_W)'(s2_ay_r);
    s3_key_r <= s2_key_r;
    s3_pt_r  <= s2_pt_r;
  end

  // Stage three: relax the key and track the nearest node outside the tree.
  assign dsum    = DIST_W'(s3_sqx_r) + DIST_W'(s3_sqy_r);
  assign new_key = (first_r || (dsum < s3_key_r)) ? dsum : s3_key_r;
  assign better  = s3_vld_r && !tree_r[s3_idx_r] && (new_key < best_key_r);

  always_ff @(posedge clk) begin
    if (clear_best) begin
      best_key_r <= '1;
    end else if (better) begin
      best_key_r <= new_key;
      best_idx_r <= s3_idx_r;
      best_pt_r  <= s3_pt_r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kbc_select.sv -----
// Rank selector: stores tree edge weights and finds the one of a given rank by counting.
`default_nettype none
module kbc_select #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kbc_pkg::weight_msg_t             weight,
  input  logic [$clog2(MAX_POINTS)-1:0]    weight_idx,
  input  logic                             start,
  input  logic [$clog2(MAX_POINTS+1)-1:0]  num_w,
  input  logic [$clog2(MAX_POINTS+1)-1:0]  rank,
  output logic                             done,
  output kbc_pkg::dist_t                   result
);
  import kbc_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS+1);

  dist_t w_mem [MAX_POINTS];
  dist_t q;

  sel_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, rd_addr, last_idx;
  dist_t            cand_r, cand_nxt;
  logic [CNT_W-1:0] less_r, le_r;
  logic             vld_r, scan_rd, cnt_clr;

  assign last_idx = IDX_W'(num_w - 1'b1);

  always_ff @(posedge clk) begin
    if (weight.valid) begin
      w_mem[weight_idx] <= weight.data;
    end
    q <= w_mem[rd_addr];
  end

  // Candidate loop over weights, counting smaller and not-larger entries.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cand_nxt  = cand_r;
    rd_addr   = '0;
    scan_rd   = 1'b0;
    cnt_clr   = 1'b0;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          i_nxt     = '0;
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        rd_addr   = i_r;
        state_nxt = S_CAPI;
      end
      S_CAPI: begin
        cand_nxt  = q;
        cnt_clr   = 1'b1;
        j_nxt     = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = j_r;
        scan_rd = 1'b1;
        if (j_r == last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if ((less_r < rank) && (rank <= le_r)) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RDI;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign result = cand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    cand_r <= cand_nxt;
    if (cnt_clr) begin
      less_r <= '0;
      le_r   <= '0;
    end else if (vld_r) begin
      less_r <= less_r + CNT_W'(q < cand_r);
      le_r   <= le_r + CNT_W'(q <= cand_r);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kbc_isqrt.sv -----
// Bit-serial ceiling square root with one shared squaring multiplier.
`default_nettype none
module kbc_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  kbc_pkg::dist_t value,
  output logic           done,
  output kbc_pkg::root_t root
);
  import kbc_pkg::*;

  localparam int BIT_W = $clog2(ROOT_W);

  sqrt_state_t        state_r, state_nxt;
  dist_t              d_r, d_nxt;
  root_t              r_r, r_nxt, trial, mul_a;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [2*ROOT_W-1:0] sq;

  assign trial = r_r | (ROOT_W'(1) << bit_r);
  assign mul_a = (state_r == Q_FIX) ? r_r : trial;
  assign sq    = mul_a * mul_a;

  // One result bit per cycle, then a final round-up step.
  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    bit_nxt   = bit_r;
    done      = 1'b0;
    root      = r_r;
    case (state_r)
      Q_IDLE: begin
        if (start) begin
          d_nxt     = value;
          r_nxt     = '0;
          bit_nxt   = BIT_W'(ROOT_W - 1);
          state_nxt = Q_STEP;
        end
      end
      Q_STEP: begin
        if (sq <= (2*ROOT_W)'(d_r)) begin
          r_nxt = trial;
        end
        if (bit_r == '0) begin
          state_nxt = Q_FIX;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      Q_FIX: begin
        if (sq < (2*ROOT_W)'(d_r)) begin
          root = r_r + 1'b1;
        end
        done      = 1'b1;
        state_nxt = Q_IDLE;
      end
      default: begin
        state_nxt = Q_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/kruskal_bottleneck_clustering.sv -----
// Top level: point loading, target register, phase control and result register.
//
//   channel  | direction | ports
//   in_      | input     | in_valid, in_ready, in_point_x, in_point_y, in_last_point
//   out_     | output    | out_valid, out_ready, out_radius, out_overflow
//   cfg_     | APB write | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata, ...
//
// Points load at one per cycle while in_ready is high. After the last point, with n stored
// points and n above the target, the Prim scan, the rank search and the root run in turn;
// the result then moves into the output register, and input stays stalled until then. That
// move waits while the previous result is still unaccepted.
// The output register lets loading of the next set run while a result waits.
// Reset is synchronous and active low; no memory needs clearing.
`default_nettype none
module kruskal_bottleneck_clustering #(
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_point_x,
  input  logic signed [15:0]            in_point_y,
  input  logic                          in_last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [16:0]                   out_radius,
  output logic                          out_overflow,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import kbc_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS+1);
  localparam int CMP_W = ((CNT_W > TARGET_W) ? CNT_W : TARGET_W) + 1;

  top_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt, n_r, n_nxt, rank_r, rank_nxt, n_val;
  logic                 ovf_r, ovf_nxt, res_ovf_r, res_ovf_nxt, ovf_after;
  root_t                res_radius_r, res_radius_nxt;
  logic [TARGET_W-1:0]  target_r, target_eff;
  logic                 out_valid_r, out_valid_nxt;
  root_t                out_radius_r, out_radius_nxt;
  logic                 out_ovf_r, out_ovf_nxt;
  logic                 in_fire, pt_wr_en, has_room, load_out, cfg_wr;
  logic                 mst_start, sel_start, sqrt_start;
  logic                 mst_done, sel_done, sqrt_done;
  weight_msg_t          weight;
  logic [IDX_W-1:0]     weight_idx;
  dist_t                sel_result;
  root_t                root;
  point_t               wr_pt;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_TARGET);
  assign cfg_prdata = (cfg_paddr[2] == REG_TARGET) ? CFG_W'(target_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_W'(1);
    end else if (cfg_wr) begin
      target_r <= cfg_pwdata[TARGET_W-1:0];
    end
  end

  assign target_eff = (target_r == '0) ? TARGET_W'(1) : target_r;

  assign in_ready  = (state_r == T_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign has_room  = (count_r < CNT_W'(MAX_POINTS));
  assign pt_wr_en  = in_fire && has_room;
  assign n_val     = has_room ? count_r + 1'b1 : count_r;
  assign ovf_after = ovf_r || !has_room;
  assign wr_pt.x   = in_point_x;
  assign wr_pt.y   = in_point_y;

  // Phase control.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    n_nxt          = n_r;
    rank_nxt       = rank_r;
    res_ovf_nxt    = res_ovf_r;
    res_radius_nxt = res_radius_r;
    mst_start      = 1'b0;
    sel_start      = 1'b0;
    sqrt_start     = 1'b0;
    load_out       = 1'b0;
    case (state_r)
      T_LOAD: begin
        if (in_fire) begin
          count_nxt = n_val;
          ovf_nxt   = ovf_after;
          if (in_last_point) begin
            count_nxt   = '0;
            ovf_nxt     = 1'b0;
            n_nxt       = n_val;
            res_ovf_nxt = ovf_after;
            rank_nxt    = CNT_W'(CMP_W'(n_val) - CMP_W'(target_eff));
            if (CMP_W'(n_val) <= CMP_W'(target_eff)) begin
              res_radius_nxt = '0;
              state_nxt      = T_OUT;
            end else begin
              mst_start = 1'b1;
              state_nxt = T_MST;
            end
          end
        end
      end
      T_MST: begin
        if (mst_done) begin
          sel_start = 1'b1;
          state_nxt = T_SEL;
        end
      end
      T_SEL: begin
        if (sel_done) begin
          sqrt_start = 1'b1;
          state_nxt  = T_SQRT;
        end
      end
      T_SQRT: begin
        if (sqrt_done) begin
          res_radius_nxt = root;
          state_nxt      = T_OUT;
        end
      end
      T_OUT: begin
        if (!out_valid_r) begin
          load_out  = 1'b1;
          state_nxt = T_LOAD;
        end
      end
      default: begin
        state_nxt = T_LOAD;
      end
    endcase
  end

  // Output register.
  assign out_valid_nxt  = load_out ? 1'b1 : (out_valid_r && !out_ready);
  assign out_radius_nxt = load_out ? res_radius_r : out_radius_r;
  assign out_ovf_nxt    = load_out ? res_ovf_r : out_ovf_r;

  assign out_valid    = out_valid_r;
  assign out_radius   = out_radius_r;
  assign out_overflow = out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    rank_r       <= rank_nxt;
    res_ovf_r    <= res_ovf_nxt;
    res_radius_r <= res_radius_nxt;
    out_radius_r <= out_radius_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  kbc_mst #(.MAX_POINTS(MAX_POINTS)) u_mst (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_wr_en   (pt_wr_en),
    .pt_wr_idx  (count_r[IDX_W-1:0]),
    .pt_wr_data (wr_pt),
    .start      (mst_start),
    .num_points (n_r),
    .weight     (weight),
    .weight_idx (weight_idx),
    .done       (mst_done)
  );

  kbc_select #(.MAX_POINTS(MAX_POINTS)) u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .weight     (weight),
    .weight_idx (weight_idx),
    .start      (sel_start),
    .num_w      (CNT_W'(n_r - 1'b1)),
    .rank       (rank_r),
    .done       (sel_done),
    .result     (sel_result)
  );

  kbc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (sel_result),
    .done  (sqrt_done),
    .root  (root)
  );

endmodule
`default_nettype wire
